FILE: sv/pte_pkg.sv
`timescale 1ns / 1ps
// Package for the two-level page table engine: sizes, operation and status codes,
// controller states and the command and status structs between controller and datapath.
// It depends on nothing else.
package pte_pkg;

   localparam int TABLE_POOL        = 8;
   localparam int ENTRIES_PER_TABLE = 1024;

   localparam int IDX_W       = $clog2(ENTRIES_PER_TABLE);
   localparam int DIR_ENTRIES = 1 << IDX_W;
   localparam int TBL_IDX_W   = $clog2(TABLE_POOL);
   localparam int TBL_DEPTH   = TABLE_POOL * ENTRIES_PER_TABLE;
   localparam int TBL_ADDR_W  = TBL_IDX_W + IDX_W;
   localparam int NFT_W       = $clog2(TABLE_POOL + 1);
   localparam int DIR_W       = TBL_IDX_W + 1;
   localparam int SWEEP_W     = IDX_W + 1;
   localparam int OFFSET_W    = 12;
   localparam int VA_W        = 32;
   localparam int FRAME_W     = VA_W - OFFSET_W;

   localparam logic [NFT_W-1:0]    FIRST_FREE_TABLE = NFT_W'(2);
   localparam logic [OFFSET_W-1:0] ENTRY_PRESENT    = 12'h001;
   localparam logic [OFFSET_W-1:0] ENTRY_WRITABLE   = 12'h002;

   localparam logic [1:0] FUNC_MAP       = 2'd0;
   localparam logic [1:0] FUNC_UNMAP     = 2'd1;
   localparam logic [1:0] FUNC_TRANSLATE = 2'd2;

   localparam logic [1:0] STATUS_DONE        = 2'd0;
   localparam logic [1:0] STATUS_NO_TABLE    = 2'd1;
   localparam logic [1:0] STATUS_NOT_PRESENT = 2'd2;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_DIR,
      ST_CLEAR,
      ST_TBL
   } state_type;

   typedef enum logic [2:0] {
      TW_NONE,
      TW_INIT,
      TW_ENTRY,
      TW_ZERO,
      TW_CLEAR
   } tbl_wr_type;

   typedef enum logic [1:0] {
      RS_DONE,
      RS_NO_TABLE,
      RS_NOT_PRESENT,
      RS_TRANSLATE
   } rsp_sel_type;

   typedef struct packed {
      logic        req_load;
      logic        dir_rd;
      logic        dir_wr_init;
      logic        dir_wr_alloc;
      logic        tbl_rd;
      tbl_wr_type  tbl_wr;
      logic        alloc;
      logic        cnt_clr;
      logic        cnt_inc;
      logic        rsp_load;
      rsp_sel_type rsp_sel;
   } ctl_cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       dir_present;
      logic       pool_full;
      logic       sweep_last;
      logic       clear_last;
      logic       out_free;
   } dp_stat_type;

endpackage

FILE: sv/pte_channels.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and response words of the engine.
// They depend on nothing else.
interface pte_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [31:0] virt_addr;
   logic [31:0] phys_addr;
   logic [11:0] page_flags;

   modport source (output valid, output func, output virt_addr, output phys_addr,
                   output page_flags, input ready);
   modport sink   (input valid, input func, input virt_addr, input phys_addr,
                   input page_flags, output ready);
endinterface

interface pte_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] phys_result;
   logic [1:0]  status;

   modport source (output valid, output phys_result, output status, input ready);
   modport sink   (input valid, input phys_result, input status, output ready);
endinterface

FILE: sv/pte_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with a registered read.
// It depends on nothing else.
module pte_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/pte_ctrl.sv
`timescale 1ns / 1ps
// Controller of the page table engine: the state machine that sequences the
// initialisation sweep, directory and table accesses and table clearing. Uses pte_pkg.
module pte_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pte_pkg::dp_stat_type stat,
   output pte_pkg::ctl_cmd_type cmd
);
   import pte_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (stat.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DIR;
            end
         end
         ST_DIR: begin
            case (stat.func)
               FUNC_MAP: begin
                  if (!stat.dir_present && !stat.pool_full) begin
                     state_in = ST_CLEAR;
                  end else if (stat.out_free) begin
                     state_in = ST_IDLE;
                  end
               end
               FUNC_TRANSLATE: begin
                  if (stat.dir_present) begin
                     state_in = ST_TBL;
                  end else if (stat.out_free) begin
                     state_in = ST_IDLE;
                  end
               end
               default: begin
                  if (stat.out_free) begin
                     state_in = ST_IDLE;
                  end
               end
            endcase
         end
         ST_CLEAR: begin
            if (stat.clear_last && stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_TBL: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_INIT: begin
            cmd.dir_wr_init = 1'b1;
            cmd.tbl_wr      = TW_INIT;
            cmd.cnt_inc     = 1'b1;
         end
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.req_load = req_valid;
            cmd.dir_rd   = req_valid;
         end
         ST_DIR: begin
            case (stat.func)
               FUNC_MAP: begin
                  if (stat.dir_present) begin
                     if (stat.out_free) begin
                        cmd.tbl_wr   = TW_ENTRY;
                        cmd.rsp_load = 1'b1;
                        cmd.rsp_sel  = RS_DONE;
                     end
                  end else if (stat.pool_full) begin
                     cmd.rsp_load = stat.out_free;
                     cmd.rsp_sel  = RS_NO_TABLE;
                  end else begin
                     cmd.dir_wr_alloc = 1'b1;
                     cmd.alloc        = 1'b1;
                     cmd.cnt_clr      = 1'b1;
                  end
               end
               FUNC_UNMAP: begin
                  if (stat.out_free) begin
                     cmd.rsp_load = 1'b1;
                     if (stat.dir_present) begin
                        cmd.tbl_wr  = TW_ZERO;
                        cmd.rsp_sel = RS_DONE;
                     end else begin
                        cmd.rsp_sel = RS_NOT_PRESENT;
                     end
                  end
               end
               FUNC_TRANSLATE: begin
                  if (stat.dir_present) begin
                     cmd.tbl_rd = 1'b1;
                  end else begin
                     cmd.rsp_load = stat.out_free;
                     cmd.rsp_sel  = RS_NOT_PRESENT;
                  end
               end
               default: begin
                  cmd.rsp_load = stat.out_free;
                  cmd.rsp_sel  = RS_DONE;
               end
            endcase
         end
         ST_CLEAR: begin
            if (!stat.clear_last) begin
               cmd.tbl_wr  = TW_CLEAR;
               cmd.cnt_inc = 1'b1;
            end else if (stat.out_free) begin
               cmd.tbl_wr   = TW_CLEAR;
               cmd.rsp_load = 1'b1;
               cmd.rsp_sel  = RS_DONE;
            end
         end
         ST_TBL: begin
            cmd.rsp_load = stat.out_free;
            cmd.rsp_sel  = RS_TRANSLATE;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // A request is only taken once the sweep has laid down the identity tables.
   a_no_accept_in_init: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INIT) |-> !cmd.req_load)
      else $error("request taken during initialisation sweep");

   // Every accepted word is followed by a directory lookup.
   a_accept_then_dir: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_DIR))
      else $error("accepted word not followed by directory lookup");

endmodule

FILE: sv/pte_datapath.sv
`timescale 1ns / 1ps
// Datapath of the page table engine: request registers, directory and table RAMs,
// the free-table and sweep counters and the response register. Uses pte_pkg and pte_ram.
module pte_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  pte_pkg::ctl_cmd_type cmd,
   output pte_pkg::dp_stat_type stat,
   input  logic [1:0]           req_func,
   input  logic [31:0]          req_virt_addr,
   input  logic [31:0]          req_phys_addr,
   input  logic [11:0]          req_page_flags,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [31:0]          rsp_phys_result,
   output logic [1:0]           rsp_status
);
   import pte_pkg::*;

   logic [1:0]           func_ff, func_in;
   logic [VA_W-1:0]      virt_ff, virt_in;
   logic [FRAME_W-1:0]   frame_ff, frame_in;
   logic [OFFSET_W-1:0]  flags_ff, flags_in;
   logic [NFT_W-1:0]     nft_ff, nft_in;
   logic [TBL_IDX_W-1:0] alloc_idx_ff, alloc_idx_in;
   logic [SWEEP_W-1:0]   cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VA_W-1:0]      rsp_result_ff, rsp_result_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;

   logic                  dir_wr_en;
   logic [IDX_W-1:0]      dir_wr_addr;
   logic [DIR_W-1:0]      dir_wr_data;
   logic [DIR_W-1:0]      dir_q;
   logic                  dir_present;
   logic [TBL_IDX_W-1:0]  dir_idx;
   logic [IDX_W-1:0]      pdi;
   logic [IDX_W-1:0]      pti;
   logic                  tbl_wr_en;
   logic [TBL_ADDR_W-1:0] tbl_wr_addr;
   logic [VA_W-1:0]       tbl_wr_data;
   logic [VA_W-1:0]       tbl_q;
   logic [VA_W-1:0]       new_entry;
   logic                  pool_full;
   logic                  out_free;

   assign pdi         = virt_ff[VA_W-1 -: IDX_W];
   assign pti         = virt_ff[OFFSET_W +: IDX_W];
   assign dir_present = dir_q[DIR_W-1];
   assign dir_idx     = dir_q[TBL_IDX_W-1:0];
   assign new_entry   = {frame_ff, flags_ff | ENTRY_PRESENT};
   assign pool_full   = (nft_ff >= NFT_W'(TABLE_POOL));
   assign out_free    = !rsp_valid_ff || rsp_ready;

   always_comb begin
      func_in       = func_ff;
      virt_in       = virt_ff;
      frame_in      = frame_ff;
      flags_in      = flags_ff;
      nft_in        = nft_ff;
      alloc_idx_in  = alloc_idx_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;
      rsp_status_in = rsp_status_ff;
      if (cmd.req_load) begin
         func_in  = req_func;
         virt_in  = req_virt_addr;
         frame_in = req_phys_addr[VA_W-1:OFFSET_W];
         flags_in = req_page_flags;
      end
      if (cmd.alloc) begin
         nft_in       = nft_ff + NFT_W'(1);
         alloc_idx_in = nft_ff[TBL_IDX_W-1:0];
      end
      if (cmd.cnt_clr) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + SWEEP_W'(1);
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         case (cmd.rsp_sel)
            RS_DONE: begin
               rsp_result_in = '0;
               rsp_status_in = STATUS_DONE;
            end
            RS_NO_TABLE: begin
               rsp_result_in = '0;
               rsp_status_in = STATUS_NO_TABLE;
            end
            RS_NOT_PRESENT: begin
               rsp_result_in = '0;
               rsp_status_in = STATUS_NOT_PRESENT;
            end
            RS_TRANSLATE: begin
               if (tbl_q[0]) begin
                  rsp_result_in = {tbl_q[VA_W-1:OFFSET_W], virt_ff[OFFSET_W-1:0]};
                  rsp_status_in = STATUS_DONE;
               end else begin
                  rsp_result_in = '0;
                  rsp_status_in = STATUS_NOT_PRESENT;
               end
            end
            default: begin
               rsp_result_in = '0;
               rsp_status_in = STATUS_DONE;
            end
         endcase
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nft_ff       <= FIRST_FREE_TABLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         nft_ff       <= nft_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      virt_ff       <= virt_in;
      frame_ff      <= frame_in;
      flags_ff      <= flags_in;
      alloc_idx_ff  <= alloc_idx_in;
      rsp_result_ff <= rsp_result_in;
      rsp_status_ff <= rsp_status_in;
   end

   // During the sweep the first two directory entries point at tables 0 and 1.
   always_comb begin
      dir_wr_en = (cmd.dir_wr_init && !cnt_ff[SWEEP_W-1]) || cmd.dir_wr_alloc;
      if (cmd.dir_wr_alloc) begin
         dir_wr_addr = pdi;
         dir_wr_data = {1'b1, nft_ff[TBL_IDX_W-1:0]};
      end else begin
         dir_wr_addr = cnt_ff[IDX_W-1:0];
         dir_wr_data = {(cnt_ff[IDX_W-1:1] == '0), TBL_IDX_W'(cnt_ff[0])};
      end
   end

   // Tables 0 and 1 are contiguous, so sweep slot s holds frame s.
   always_comb begin
      tbl_wr_en   = 1'b1;
      tbl_wr_addr = {dir_idx, pti};
      tbl_wr_data = '0;
      case (cmd.tbl_wr)
         TW_NONE: begin
            tbl_wr_en = 1'b0;
         end
         TW_INIT: begin
            tbl_wr_addr = TBL_ADDR_W'(cnt_ff);
            tbl_wr_data = VA_W'({cnt_ff, ENTRY_PRESENT | ENTRY_WRITABLE});
         end
         TW_ENTRY: begin
            tbl_wr_data = new_entry;
         end
         TW_ZERO: begin
            tbl_wr_data = '0;
         end
         TW_CLEAR: begin
            tbl_wr_addr = {alloc_idx_ff, cnt_ff[IDX_W-1:0]};
            tbl_wr_data = (cnt_ff[IDX_W-1:0] == pti) ? new_entry : '0;
         end
         default: begin
            tbl_wr_en = 1'b0;
         end
      endcase
   end

   pte_ram #(
      .WIDTH (DIR_W),
      .DEPTH (DIR_ENTRIES)
   ) u_dir_ram (
      .clock   (clock),
      .wr_en   (dir_wr_en),
      .wr_addr (dir_wr_addr),
      .wr_data (dir_wr_data),
      .rd_en   (cmd.dir_rd),
      .rd_addr (req_virt_addr[VA_W-1 -: IDX_W]),
      .rd_data (dir_q)
   );

   pte_ram #(
      .WIDTH (VA_W),
      .DEPTH (TBL_DEPTH)
   ) u_tbl_ram (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (cmd.tbl_rd),
      .rd_addr ({dir_idx, pti}),
      .rd_data (tbl_q)
   );

   always_comb begin
      stat.func        = func_ff;
      stat.dir_present = dir_present;
      stat.pool_full   = pool_full;
      stat.sweep_last  = &cnt_ff;
      stat.clear_last  = &cnt_ff[IDX_W-1:0];
      stat.out_free    = out_free;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_phys_result = rsp_result_ff;
   assign rsp_status      = rsp_status_ff;

   a_no_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("response word overwritten before it was taken");

   a_alloc_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc |-> (!pool_full && !dir_present))
      else $error("table allocated with empty pool or present directory entry");

   a_alloc_advances: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc |=> (nft_ff == $past(nft_ff) + NFT_W'(1)))
      else $error("free table counter did not advance on allocation");

   a_tbl_rd_present: assert property (@(posedge clock) disable iff (reset)
      cmd.tbl_rd |-> (dir_present && !tbl_wr_en))
      else $error("table read without a present directory entry");

endmodule

FILE: sv/two_level_page_table_engine.sv
`timescale 1ns / 1ps
// Top level of the two-level page table engine: joins controller and datapath to the
// request and response channels. Uses pte_pkg, pte_channels, pte_ctrl and pte_datapath.
//
//   Channel   Direction  Modport  Word
//   req_bus   in         sink     func, virt_addr, phys_addr, page_flags
//   rsp_bus   out        source   phys_result, status
//
// After reset a sweep writes the directory and the identity tables 0 and 1;
// req_bus.ready stays low until it ends.
// Unmap, func code 3, map without allocation and translate with a directory miss pass through
// the idle and directory states; a translate that reaches the table goes on to the table state.
// Map that allocates a table enters the clear state: the table RAM's one write port clears the
// new table an entry a cycle, the last once the output is free. One word is worked on at a time.
// The response sits in an output register; the engine takes the next word while it waits
// and stalls only in the last step of that word if the response is still not taken.
module two_level_page_table_engine (
   input  logic clock,
   input  logic reset,
   pte_req_if.sink   req_bus,
   pte_rsp_if.source rsp_bus
);
   import pte_pkg::*;

   ctl_cmd_type cmd;
   dp_stat_type stat;
   logic        req_ready;

   pte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pte_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_func        (req_bus.func),
      .req_virt_addr   (req_bus.virt_addr),
      .req_phys_addr   (req_bus.phys_addr),
      .req_page_flags  (req_bus.page_flags),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_phys_result (rsp_bus.phys_result),
      .rsp_status      (rsp_bus.status)
   );

   assign req_bus.ready = req_ready;

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for two_level_page_table_engine: a directed opening, then random
// map, unmap, translate and unused-code words, checked against a behavioural page walk kept in the bench.
// Depends on pte_pkg, pte_channels and the engine's RTL.
module tb;
   import pte_pkg::*;

   localparam logic [1:0] FUNC_NONE   = 2'd3;
   localparam int         CYCLE_LIMIT = 200000;
   localparam int         RANDOM_REQS = 500;
   localparam int         TAIL_CYCLES = 40;

   typedef struct {
      logic [1:0]          func;
      logic [VA_W-1:0]     virt_addr;
      logic [VA_W-1:0]     phys_addr;
      logic [OFFSET_W-1:0] page_flags;
      bit                  drain;
   } page_req_type;

   typedef struct {
      logic [VA_W-1:0] phys_result;
      logic [1:0]      status;
   } page_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pte_req_if req_bus ();
   pte_rsp_if rsp_bus ();

   two_level_page_table_engine i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   bit              dir_valid [DIR_ENTRIES];
   int              dir_table [DIR_ENTRIES];
   logic [VA_W-1:0] pt_mem [TBL_DEPTH];
   int              free_table;

   page_req_type pending_reqs[$];
   page_rsp_type expected_rsps[$];
   page_req_type drive_req;
   page_req_type taken_req;
   page_rsp_type want_rsp;

   int hot_dirs [10]   = '{0, 1, 2, 1023, 'h155, 'h2AA, 'h3F0, 'h0FF, 'h200, 'h100};
   int hot_entries [8] = '{0, 1, 2, 511, 512, 1022, 1023, 'h155};

   bit          req_fire;
   int          burst_left;
   int          idle_left;
   logic [7:0]  stall_tick = '0;
   int unsigned cycle_count;
   int unsigned error_count;
   int unsigned func_count [4];
   int unsigned status_count [3];
   int unsigned tables_allocated;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic page_rsp_type walk_page_table(page_req_type r);
      page_rsp_type     o;
      logic [IDX_W-1:0] d;
      logic [IDX_W-1:0] e;
      logic [VA_W-1:0]  pte;
      o.phys_result = '0;
      o.status      = STATUS_DONE;
      d = r.virt_addr[VA_W-1 -: IDX_W];
      e = r.virt_addr[OFFSET_W +: IDX_W];
      case (r.func)
         FUNC_MAP: begin
            if (!dir_valid[d]) begin
               if (free_table >= TABLE_POOL) begin
                  o.status = STATUS_NO_TABLE;
               end else begin
                  for (int i = 0; i < ENTRIES_PER_TABLE; i++)
                     pt_mem[free_table * ENTRIES_PER_TABLE + i] = '0;
                  dir_table[d] = free_table;
                  dir_valid[d] = 1'b1;
                  free_table++;
                  tables_allocated++;
               end
            end
            if (o.status == STATUS_DONE)
               pt_mem[dir_table[d] * ENTRIES_PER_TABLE + e] =
                  {r.phys_addr[VA_W-1:OFFSET_W], r.page_flags | ENTRY_PRESENT};
         end
         FUNC_UNMAP: begin
            if (dir_valid[d])
               pt_mem[dir_table[d] * ENTRIES_PER_TABLE + e] = '0;
            else
               o.status = STATUS_NOT_PRESENT;
         end
         FUNC_TRANSLATE: begin
            if (!dir_valid[d]) begin
               o.status = STATUS_NOT_PRESENT;
            end else begin
               pte = pt_mem[dir_table[d] * ENTRIES_PER_TABLE + e];
               if ((pte[OFFSET_W-1:0] & ENTRY_PRESENT) != '0)
                  o.phys_result = {pte[VA_W-1:OFFSET_W], r.virt_addr[OFFSET_W-1:0]};
               else
                  o.status = STATUS_NOT_PRESENT;
            end
         end
         default: begin
         end
      endcase
      func_count[r.func]++;
      status_count[o.status]++;
      return o;
   endfunction

   function automatic page_req_type random_page_req();
      page_req_type     r;
      int unsigned      pick;
      logic [IDX_W-1:0] d;
      logic [IDX_W-1:0] e;
      pick = $urandom_range(99);
      if (pick < 35)
         r.func = FUNC_MAP;
      else if (pick < 50)
         r.func = FUNC_UNMAP;
      else if (pick < 95)
         r.func = FUNC_TRANSLATE;
      else
         r.func = FUNC_NONE;
      d = ($urandom_range(9) < 7) ? IDX_W'(hot_dirs[$urandom_range(9)]) : IDX_W'($urandom);
      e = ($urandom_range(9) < 6) ? IDX_W'(hot_entries[$urandom_range(7)]) : IDX_W'($urandom);
      r.virt_addr  = {d, e, OFFSET_W'($urandom)};
      r.phys_addr  = $urandom;
      r.page_flags = OFFSET_W'($urandom);
      r.drain      = 1'b0;
      return r;
   endfunction

   task automatic add_req(logic [1:0] func, logic [VA_W-1:0] virt, logic [VA_W-1:0] phys,
                          logic [OFFSET_W-1:0] flags, bit drain);
      page_req_type r;
      r.func       = func;
      r.virt_addr  = virt;
      r.phys_addr  = phys;
      r.page_flags = flags;
      r.drain      = drain;
      pending_reqs.push_back(r);
   endtask

   // Request words change on the falling edge; a new word is offered once the last one went.
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid      <= 1'b0;
         req_bus.func       <= FUNC_NONE;
         req_bus.virt_addr  <= '0;
         req_bus.phys_addr  <= '0;
         req_bus.page_flags <= '0;
      end else if (req_fire || !req_bus.valid) begin
         if (idle_left > 0) begin
            idle_left--;
            req_bus.valid <= 1'b0;
         end else if (pending_reqs.size() == 0 ||
                      (pending_reqs[0].drain && expected_rsps.size() != 0)) begin
            req_bus.valid <= 1'b0;
         end else begin
            drive_req = pending_reqs.pop_front();
            req_bus.func       <= drive_req.func;
            req_bus.virt_addr  <= drive_req.virt_addr;
            req_bus.phys_addr  <= drive_req.phys_addr;
            req_bus.page_flags <= drive_req.page_flags;
            req_bus.valid      <= 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 16);
               idle_left  = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
      end
   end

   always @(negedge clock) begin
      stall_tick <= stall_tick + 8'd1;
      case (stall_tick[7:6])
         2'd0:    rsp_bus.ready <= 1'b1;
         2'd1:    rsp_bus.ready <= 1'($urandom_range(1));
         2'd2:    rsp_bus.ready <= (stall_tick[1:0] == 2'b11);
         default: rsp_bus.ready <= ($urandom_range(3) == 0);
      endcase
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         req_fire = 1'b0;
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (expected_rsps.size() == 0) begin
               $error("response word with nothing outstanding: phys_result %h, status %0d",
                      rsp_bus.phys_result, rsp_bus.status);
               error_count++;
            end else begin
               want_rsp = expected_rsps.pop_front();
               if (rsp_bus.phys_result !== want_rsp.phys_result) begin
                  $error("phys_result: expected %h, got %h",
                         want_rsp.phys_result, rsp_bus.phys_result);
                  error_count++;
               end
               if (rsp_bus.status !== want_rsp.status) begin
                  $error("status: expected %0d, got %0d", want_rsp.status, rsp_bus.status);
                  error_count++;
               end
            end
         end
         if (!reset && req_bus.valid && req_bus.ready) begin
            req_fire = 1'b1;
            taken_req.func       = req_bus.func;
            taken_req.virt_addr  = req_bus.virt_addr;
            taken_req.phys_addr  = req_bus.phys_addr;
            taken_req.page_flags = req_bus.page_flags;
            taken_req.drain      = 1'b0;
            expected_rsps.push_back(walk_page_table(taken_req));
         end
      end
   end

   initial begin
      page_req_type fill_req;

      // Directory entries 0 and 1 start out identity-mapping the first 8 MiB.
      for (int t = 0; t < 2; t++) begin
         dir_valid[t] = 1'b1;
         dir_table[t] = t;
         for (int i = 0; i < ENTRIES_PER_TABLE; i++)
            pt_mem[t * ENTRIES_PER_TABLE + i] = VA_W'((t * ENTRIES_PER_TABLE + i) << OFFSET_W)
                                                | ENTRY_PRESENT | ENTRY_WRITABLE;
      end
      free_table = FIRST_FREE_TABLE;

      add_req(FUNC_TRANSLATE, 32'h0000_0ABC, '0, '0, 1'b0);
      add_req(FUNC_TRANSLATE, 32'h007F_FFFF, '0, '0, 1'b0);
      add_req(FUNC_TRANSLATE, 32'hFFFF_FFFF, '0, '0, 1'b0);
      add_req(FUNC_UNMAP,     32'hFFC0_0000, '0, '0, 1'b0);
      add_req(FUNC_NONE,      32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF, 1'b0);
      add_req(FUNC_MAP,       32'hFFFF_F123, 32'hFFFF_FFFF, 12'hFFF, 1'b0);
      add_req(FUNC_TRANSLATE, 32'hFFFF_FFFF, '0, '0, 1'b0);
      add_req(FUNC_TRANSLATE, 32'hFFC0_0000, '0, '0, 1'b0);
      add_req(FUNC_MAP,       32'hFFC0_0000, 32'h0000_0000, 12'h000, 1'b0);
      add_req(FUNC_TRANSLATE, 32'hFFC0_0FFF, '0, '0, 1'b0);
      add_req(FUNC_MAP,       32'h0000_1000, 32'h1234_5000, 12'h004, 1'b1);
      add_req(FUNC_TRANSLATE, 32'h0000_1234, '0, '0, 1'b0);
      add_req(FUNC_UNMAP,     32'h0000_1000, '0, '0, 1'b0);
      add_req(FUNC_TRANSLATE, 32'h0000_1000, '0, '0, 1'b0);
      add_req(FUNC_UNMAP,     32'h0000_1000, '0, '0, 1'b0);
      add_req(FUNC_MAP,       32'h0080_0000, 32'hA5A5_A000, 12'hFFE, 1'b0);
      add_req(FUNC_TRANSLATE, 32'h0080_0ABC, '0, '0, 1'b0);
      add_req(FUNC_TRANSLATE, 32'h0080_1000, '0, '0, 1'b0);

      // Every so often the sender holds back until all responses are in.
      for (int n = 0; n < RANDOM_REQS; n++) begin
         fill_req       = random_page_req();
         fill_req.drain = (n % 125 == 0);
         pending_reqs.push_back(fill_req);
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_bus.valid)
         @(negedge clock);
      while (expected_rsps.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Covered %0d maps, %0d unmaps, %0d translates and %0d unused codes.",
               func_count[FUNC_MAP], func_count[FUNC_UNMAP], func_count[FUNC_TRANSLATE],
               func_count[FUNC_NONE]);
      $display("Responses: %0d done, %0d out of tables, %0d not present; %0d tables, %0d cycles.",
               status_count[STATUS_DONE], status_count[STATUS_NO_TABLE],
               status_count[STATUS_NOT_PRESENT], tables_allocated, cycle_count);
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
